### rtl/core/bal_pkg.sv
`timescale 1ns / 1ps
package bal_pkg;
  localparam int unsigned DepthDefault = 16;
  localparam int unsigned ValW = 32;
  localparam int unsigned CmdW = 4;
  localparam int unsigned PosW = 4;
  localparam int unsigned StW = 3;
  localparam int unsigned IdxW = 5;
  localparam int unsigned CntW = 5;

  localparam logic [CmdW-1:0] CmdInsFront  = 4'd0;
  localparam logic [CmdW-1:0] CmdInsRear   = 4'd1;
  localparam logic [CmdW-1:0] CmdInsAt     = 4'd2;
  localparam logic [CmdW-1:0] CmdInsSorted = 4'd3;
  localparam logic [CmdW-1:0] CmdDelFront  = 4'd4;
  localparam logic [CmdW-1:0] CmdDelRear   = 4'd5;
  localparam logic [CmdW-1:0] CmdDelItem   = 4'd6;
  localparam logic [CmdW-1:0] CmdDelAll    = 4'd7;
  localparam logic [CmdW-1:0] CmdFind      = 4'd8;
  localparam logic [CmdW-1:0] CmdRead      = 4'd9;

  localparam logic [StW-1:0] StOk       = 3'd0;
  localparam logic [StW-1:0] StFull     = 3'd1;
  localparam logic [StW-1:0] StEmpty    = 3'd2;
  localparam logic [StW-1:0] StBadPos   = 3'd3;
  localparam logic [StW-1:0] StNotFound = 3'd4;

  // per-cycle shift command broadcast to every cell
  typedef enum logic [1:0] {
    OpHold  = 2'd0,
    OpUp    = 2'd1,  // take lower neighbor (cell i gets i-1), insert at boundary
    OpDown  = 2'd2   // take upper neighbor (cell i gets i+1)
  } cell_op_e;

  typedef struct packed {
    cell_op_e         op;
    logic [31:0]      item;
  } cell_ctl_t;
endpackage

### rtl/core/bal_if.sv
`timescale 1ns / 1ps
interface bal_cmd_if;
  logic        valid;
  logic        ready;
  logic [3:0]  command;
  logic signed [31:0] item_value;
  logic [3:0]  position;
  modport source (output valid, command, item_value, position, input ready);
  modport sink   (input valid, command, item_value, position, output ready);
endinterface

interface bal_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic signed [31:0] value;
  logic signed [4:0]  index;
  logic [4:0]  count;
  modport source (output valid, status, value, index, count, input ready);
  modport sink   (input valid, status, value, index, count, output ready);
endinterface

### rtl/core/bounded_array_list_engine_top.sv
`timescale 1ns / 1ps
// Bounded list engine: a packed list of up to DEPTH signed 32-bit entries.
// cmd_i (sink): command, item_value, position; one request at a time.
// rsp_o (source): status, value, index, count; one result per request.
// The entries sit in a row of cells. A shift moves the entries at and above
// the insert or delete point by one place; a scan reads one entry a cycle.
// Rear delete, read, unused codes and rejected requests go straight to the
// result; front, rear and positional inserts and front delete pass through
// the shift state first. Sorted insert, delete-item, delete-all and find
// scan one entry per cycle; sorted insert then shifts, delete-item on a hit.
// Requests are taken one at a time: ready returns in the cycle after the
// result is accepted.
// While the receiver stalls the result is held and no new request is taken.
// Reset clears the fill count and the handshake state; entries are not
// cleared and are never read beyond the fill count.
module bounded_array_list_engine_top #(
  parameter int unsigned DEPTH = bal_pkg::DepthDefault
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  bal_cmd_if.sink  cmd_i,
  bal_rsp_if.source rsp_o
);
  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [CW:0] DepthC = (CW + 1)'(DEPTH);

  typedef enum logic [3:0] {
    SIdle = 4'b0001, SScan = 4'b0010, SShift = 4'b0100, SOut = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic [3:0]  cmd_q;
  logic [31:0] item_q;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW:0]   ptr_q, ptr_d;    // scan / shift pointer
  logic [CW:0]   wr_q, wr_d;      // compaction write pointer
  logic [2:0]  st_q, st_d;
  logic [31:0] val_q, val_d;
  logic [4:0]  idx_q, idx_d;

  logic [31:0] ent [DEPTH];
  logic [DEPTH-1:0] en, sel;
  bal_pkg::cell_ctl_t ctl;

  // entry at the pointer
  logic [31:0] cur;
  assign cur = ent[ptr_q[AW-1:0]];

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    bal_cell u_cell (
      .clk_i(clk_i), .ctl_i(ctl), .en_i(en[g]), .sel_i(sel[g]),
      .lo_i(ent[(g == 0) ? 0 : g - 1]),
      .hi_i(ent[(g == DEPTH - 1) ? g : g + 1]),
      .q_o(ent[g])
    );
  end

  assign cmd_i.ready = (state_q == SIdle);

  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q; ptr_d = ptr_q; wr_d = wr_q;
    st_d = st_q; val_d = val_q; idx_d = idx_q;
    ctl.op = bal_pkg::OpHold;
    ctl.item = item_q;
    en = '0; sel = '0;
    case (state_q)
      SIdle: ;
      SScan: begin
        // ptr_q walks down for sorted insert, up for searches
        case (cmd_q)
          bal_pkg::CmdInsSorted: begin
            if (ptr_q == '0 || !($signed(ent[ptr_q[AW-1:0] - AW'(1)])
                > $signed(item_q))) begin
              state_d = SShift;
            end else ptr_d = ptr_q - 1'b1;
          end
          bal_pkg::CmdDelItem, bal_pkg::CmdFind: begin
            if (ptr_q >= {1'b0, cnt_q}) begin
              st_d = bal_pkg::StNotFound; state_d = SOut;
            end else if (cur == item_q) begin
              if (cmd_q == bal_pkg::CmdFind) begin
                idx_d = 5'(ptr_q); state_d = SOut;
              end else state_d = SShift;
            end else ptr_d = ptr_q + 1'b1;
          end
          default: begin // delete all: one pass, compacting
            if (ptr_q >= {1'b0, cnt_q}) begin
              if (wr_q == {1'b0, cnt_q}) st_d = bal_pkg::StNotFound;
              cnt_d = CW'(wr_q);
              state_d = SOut;
            end else begin
              if (cur != item_q) begin
                for (int k = 0; k < DEPTH; k++)
                  if (wr_q == (CW + 1)'(k)) begin
                    en[k] = 1'b1; sel[k] = 1'b1;
                  end
                ctl.op = bal_pkg::OpUp;
                ctl.item = cur;
                wr_d = wr_q + 1'b1;
              end
              ptr_d = ptr_q + 1'b1;
            end
          end
        endcase
      end
      SShift: begin
        if (cmd_q <= bal_pkg::CmdInsSorted) begin
          // insert at ptr: cells ptr..cnt move up, ptr gets item
          for (int k = 0; k < DEPTH; k++) begin
            en[k]  = ((CW + 1)'(k) >= ptr_q) && ((CW + 1)'(k) <= {1'b0, cnt_q});
            sel[k] = ((CW + 1)'(k) == ptr_q);
          end
          ctl.op = bal_pkg::OpUp;
          cnt_d = cnt_q + 1'b1;
        end else begin
          for (int k = 0; k < DEPTH; k++)
            en[k] = ((CW + 1)'(k) >= ptr_q);
          ctl.op = bal_pkg::OpDown;
          cnt_d = cnt_q - 1'b1;
        end
        state_d = SOut;
      end
      SOut: if (rsp_o.ready) state_d = SIdle;
      default: state_d = SIdle;
    endcase

    if (state_q == SIdle && cmd_i.valid) begin
      st_d = bal_pkg::StOk; val_d = '0; idx_d = '1; wr_d = '0;
      state_d = SOut;
      ptr_d = '0;
      if (cmd_i.command <= bal_pkg::CmdInsSorted && {1'b0, cnt_q} >= DepthC) begin
        st_d = bal_pkg::StFull;
      end else if (cmd_i.command >= bal_pkg::CmdDelFront &&
                   cmd_i.command <= bal_pkg::CmdRead && cnt_q == '0) begin
        st_d = bal_pkg::StEmpty;
      end else begin
        case (cmd_i.command)
          bal_pkg::CmdInsFront: state_d = SShift;
          bal_pkg::CmdInsRear: begin ptr_d = {1'b0, cnt_q}; state_d = SShift; end
          bal_pkg::CmdInsAt: begin
            if ((CW + 1)'(cmd_i.position) > {1'b0, cnt_q}) st_d = bal_pkg::StBadPos;
            else begin ptr_d = (CW + 1)'(cmd_i.position); state_d = SShift; end
          end
          bal_pkg::CmdInsSorted: begin ptr_d = {1'b0, cnt_q}; state_d = SScan; end
          bal_pkg::CmdDelFront: state_d = SShift;
          bal_pkg::CmdDelRear: cnt_d = cnt_q - 1'b1;
          bal_pkg::CmdDelItem, bal_pkg::CmdDelAll, bal_pkg::CmdFind: state_d = SScan;
          bal_pkg::CmdRead: begin
            if ((CW + 1)'(cmd_i.position) >= {1'b0, cnt_q})
              st_d = bal_pkg::StBadPos;
            else val_d = ent[AW'(cmd_i.position)];
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle; cnt_q <= '0;
    end else begin
      state_q <= state_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q <= ptr_d; wr_q <= wr_d;
    st_q <= st_d; val_q <= val_d; idx_q <= idx_d;
    if (state_q == SIdle && cmd_i.valid) begin
      cmd_q <= cmd_i.command; item_q <= cmd_i.item_value;
    end
  end

  assign rsp_o.valid  = (state_q == SOut);
  assign rsp_o.status = st_q;
  assign rsp_o.value  = val_q;
  assign rsp_o.index  = idx_q;
  assign rsp_o.count  = 5'(cnt_q);
endmodule

### rtl/core/bal_cell.sv
`timescale 1ns / 1ps
// One list slot. Each shift cycle it either keeps its entry or takes a neighbor's.
// A walking select (sel_i) marks the slot that receives the new item on an up-shift.
module bal_cell (
  input  logic               clk_i,
  input  bal_pkg::cell_ctl_t ctl_i,
  input  logic               en_i,
  input  logic               sel_i,
  input  logic [31:0]        lo_i,
  input  logic [31:0]        hi_i,
  output logic [31:0]        q_o
);
  logic [31:0] entry_q, entry_d;
  always_comb begin
    entry_d = entry_q;
    if (en_i) begin
      case (ctl_i.op)
        bal_pkg::OpUp:   entry_d = sel_i ? ctl_i.item : lo_i;
        bal_pkg::OpDown: entry_d = hi_i;
        default:         entry_d = entry_q;
      endcase
    end
  end
  always_ff @(posedge clk_i) entry_q <= entry_d;
  assign q_o = entry_q;
endmodule

### rtl/core/bal_checker.sv
`timescale 1ns / 1ps
module bal_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i, input logic in_ready_i,
  input logic out_valid_i, input logic out_ready_i,
  input logic [2:0] status_i, input logic [4:0] count_i, input logic [4:0] index_i
);
  // one request in flight: no accept while a result is pending
  a_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !in_ready_i) else $error("accept with result pending");
  a_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> out_valid_i) else $error("result dropped");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      ($stable(status_i) && $stable(count_i) && $stable(index_i)))
    else $error("result changed while stalled");
  a_st: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> status_i <= bal_pkg::StNotFound) else $error("bad status");
  a_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && status_i != bal_pkg::StOk) |-> index_i == '1)
    else $error("index on fail");
endmodule

bind bounded_array_list_engine_top bal_checker u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .in_valid_i(cmd_i.valid), .in_ready_i(cmd_i.ready),
  .out_valid_i(rsp_o.valid), .out_ready_i(rsp_o.ready),
  .status_i(rsp_o.status), .count_i(rsp_o.count), .index_i(rsp_o.index)
);

### test/bounded_array_list_engine_top_tb.sv
`timescale 1ns / 1ps
module bounded_array_list_engine_top_tb;

  localparam int unsigned Depth = bal_pkg::DepthDefault;

  typedef struct packed {
    logic [bal_pkg::StW-1:0]         status;
    logic signed [bal_pkg::ValW-1:0] value;
    logic signed [bal_pkg::IdxW-1:0] index;
    logic [bal_pkg::CntW-1:0]        count;
  } list_rsp_t;

  logic clk_i;
  logic rst_ni;

  bal_cmd_if cmd_if ();
  bal_rsp_if rsp_if ();

  bounded_array_list_engine_top #(.DEPTH(Depth)) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (cmd_if.sink),
    .rsp_o (rsp_if.source)
  );

  // shadow copy of the list
  logic signed [bal_pkg::ValW-1:0] shadow_list[Depth];
  int unsigned shadow_fill;
  list_rsp_t expected_rsps[$];
  int unsigned n_errors;
  int unsigned n_requests;
  int unsigned n_results;
  int unsigned stall_hold;  // receiver hold-off, cycles
  bit          rsp_ready_en;

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  initial begin
    #50ms;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic void shadow_put(int unsigned at, logic signed [bal_pkg::ValW-1:0] v);
    for (int unsigned i = shadow_fill; i > at; i--) shadow_list[i] = shadow_list[i-1];
    shadow_list[at] = v;
    shadow_fill++;
  endfunction

  function automatic void shadow_remove(int unsigned at);
    for (int unsigned i = at; i + 1 < shadow_fill; i++) shadow_list[i] = shadow_list[i+1];
    shadow_fill--;
  endfunction

  function automatic int shadow_find(logic signed [bal_pkg::ValW-1:0] v);
    for (int i = 0; i < int'(shadow_fill); i++) if (shadow_list[i] == v) return i;
    return -1;
  endfunction

  function automatic list_rsp_t predict_list_op(logic [bal_pkg::CmdW-1:0] cmd,
                                                logic signed [bal_pkg::ValW-1:0] v,
                                                logic [bal_pkg::PosW-1:0] pos);
    list_rsp_t r;
    int where;
    int unsigned w;
    int unsigned i;
    r.status = bal_pkg::StOk;
    r.value  = '0;
    r.index  = '1;
    if (cmd <= bal_pkg::CmdInsSorted && shadow_fill >= Depth) begin
      r.status = bal_pkg::StFull;
    end else if (cmd >= bal_pkg::CmdDelFront && cmd <= bal_pkg::CmdRead &&
                 shadow_fill == 0) begin
      r.status = bal_pkg::StEmpty;
    end else begin
      case (cmd)
        bal_pkg::CmdInsFront: shadow_put(0, v);
        bal_pkg::CmdInsRear:  shadow_put(shadow_fill, v);
        bal_pkg::CmdInsAt: begin
          if (pos > shadow_fill) r.status = bal_pkg::StBadPos;
          else shadow_put(pos, v);
        end
        bal_pkg::CmdInsSorted: begin
          i = shadow_fill;
          while (i > 0 && shadow_list[i-1] > v) i--;
          shadow_put(i, v);
        end
        bal_pkg::CmdDelFront: shadow_remove(0);
        bal_pkg::CmdDelRear:  shadow_fill--;
        bal_pkg::CmdDelItem: begin
          where = shadow_find(v);
          if (where < 0) r.status = bal_pkg::StNotFound;
          else shadow_remove(where);
        end
        bal_pkg::CmdDelAll: begin
          w = 0;
          for (i = 0; i < shadow_fill; i++)
            if (shadow_list[i] != v) begin
              shadow_list[w] = shadow_list[i];
              w++;
            end
          if (w == shadow_fill) r.status = bal_pkg::StNotFound;
          shadow_fill = w;
        end
        bal_pkg::CmdFind: begin
          where = shadow_find(v);
          if (where < 0) r.status = bal_pkg::StNotFound;
          else r.index = where[bal_pkg::IdxW-1:0];
        end
        bal_pkg::CmdRead: begin
          if (pos >= shadow_fill) r.status = bal_pkg::StBadPos;
          else r.value = shadow_list[pos];
        end
        default: ;
      endcase
    end
    r.count = shadow_fill[bal_pkg::CntW-1:0];
    return r;
  endfunction

  function automatic int unsigned short_gap();
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 3);
  endfunction

  // one request; expectation is queued when the handshake completes
  task automatic send_request(logic [bal_pkg::CmdW-1:0] cmd,
                              logic signed [bal_pkg::ValW-1:0] v,
                              logic [bal_pkg::PosW-1:0] pos, bit use_gap = 1);
    int unsigned gap;
    gap = use_gap ? short_gap() : 0;
    // valid drops between requests; the block is busy then anyway
    repeat (gap + 1) @(posedge clk_i);
    cmd_if.valid      <= 1'b1;
    cmd_if.command    <= cmd;
    cmd_if.item_value <= v;
    cmd_if.position   <= pos;
    do @(posedge clk_i); while (!cmd_if.ready);
    expected_rsps.push_back(predict_list_op(cmd, v, pos));
    n_requests++;
    cmd_if.valid <= 1'b0;
  endtask

  // receiver: random stalls when rsp_ready_en is set, plus a long hold-off when stall_hold is set
  initial begin
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_hold > 0) begin
        rsp_if.ready <= 1'b0;
        stall_hold--;
      end else if (!rsp_ready_en) begin
        rsp_if.ready <= 1'b1;
      end else if ($urandom_range(0, 3) == 0) begin
        rsp_if.ready <= 1'b0;
        repeat (short_gap() + 1) @(posedge clk_i);
        rsp_if.ready <= 1'b1;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    list_rsp_t got, exp_r;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      got = '{rsp_if.status, rsp_if.value, rsp_if.index, rsp_if.count};
      n_results++;
      if (expected_rsps.size() == 0) begin
        $display("%0t: unexpected result %p", $time, got);
        n_errors++;
      end else begin
        exp_r = expected_rsps.pop_front();
        if (got.status !== exp_r.status) begin
          $display("%0t: status exp %0d got %0d", $time, exp_r.status, got.status);
          n_errors++;
        end
        if (got.value !== exp_r.value) begin
          $display("%0t: value exp %0d got %0d", $time, exp_r.value, got.value);
          n_errors++;
        end
        if (got.index !== exp_r.index) begin
          $display("%0t: index exp %0d got %0d", $time, exp_r.index, got.index);
          n_errors++;
        end
        if (got.count !== exp_r.count) begin
          $display("%0t: count exp %0d got %0d", $time, exp_r.count, got.count);
          n_errors++;
        end
      end
    end
  end

  function automatic logic signed [bal_pkg::ValW-1:0] pick_value();
    case ($urandom_range(0, 5))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return $urandom;
      default: return $signed($urandom_range(0, 8)) - 4;
    endcase
  endfunction

  // existing value most of the time so deletes and finds hit
  function automatic logic signed [bal_pkg::ValW-1:0] pick_known();
    if (shadow_fill > 0 && $urandom_range(0, 3) != 0)
      return shadow_list[$urandom_range(0, shadow_fill - 1)];
    return pick_value();
  endfunction

  task automatic test_directed();
    send_request(bal_pkg::CmdDelFront, 0, 0);
    send_request(bal_pkg::CmdDelRear, 0, 0);
    send_request(bal_pkg::CmdFind, 5, 0);
    send_request(bal_pkg::CmdRead, 0, 0);
    send_request(bal_pkg::CmdInsAt, 1, 1);           // beyond count
    send_request(bal_pkg::CmdInsAt, 32'sh7fff_ffff, 0);
    send_request(bal_pkg::CmdInsFront, 32'sh8000_0000, 4'hf);
    send_request(bal_pkg::CmdInsRear, 32'shffff_ffff, 0);
    send_request(bal_pkg::CmdInsSorted, 0, 0);
    send_request(bal_pkg::CmdInsSorted, 0, 0);       // equal goes after
    send_request(bal_pkg::CmdInsAt, 3, 5);           // position equal to count
    send_request(bal_pkg::CmdRead, 0, 4'hf);
    send_request(bal_pkg::CmdRead, 0, 2);
    send_request(bal_pkg::CmdFind, 0, 0);
    send_request(bal_pkg::CmdFind, 12345, 0);
    send_request(bal_pkg::CmdDelItem, 12345, 0);
    send_request(bal_pkg::CmdDelAll, 42, 0);
    send_request(bal_pkg::CmdDelAll, 0, 0);
    send_request(bal_pkg::CmdDelItem, 32'sh8000_0000, 0);
    send_request(4'd10, 0, 0);
    send_request(4'd15, 32'sh5555_aaaa, 4'ha);
    send_request(bal_pkg::CmdDelFront, 0, 0);
    send_request(bal_pkg::CmdDelRear, 0, 0);
  endtask

  task automatic test_fill_and_overflow();
    repeat (Depth + 2) send_request(bal_pkg::CmdInsSorted, pick_value(), 0);
    send_request(bal_pkg::CmdInsFront, 1, 0);
    send_request(bal_pkg::CmdInsAt, 1, 0);
    send_request(bal_pkg::CmdRead, 0, 4'hf);
    send_request(bal_pkg::CmdDelAll, shadow_list[0], 0);
  endtask

  task automatic test_random_mix(int unsigned n);
    logic [bal_pkg::CmdW-1:0] cmd;
    logic [bal_pkg::PosW-1:0] pos;
    for (int unsigned k = 0; k < n; k++) begin
      // bias toward growing when short; now and then an unused code
      if ($urandom_range(0, 49) == 0)
        cmd = (bal_pkg::CmdW)'($urandom_range(10, 15));
      else if (shadow_fill < 4 && $urandom_range(0, 1))
        cmd = (bal_pkg::CmdW)'($urandom_range(0, 3));
      else cmd = (bal_pkg::CmdW)'($urandom_range(0, 9));
      pos = (shadow_fill > 0 && $urandom_range(0, 3) != 0)
            ? (bal_pkg::PosW)'($urandom_range(0, shadow_fill))
            : (bal_pkg::PosW)'($urandom);
      send_request(cmd, cmd <= bal_pkg::CmdInsSorted ? pick_value() : pick_known(), pos);
    end
  endtask

  task automatic test_backpressure();
    stall_hold = 200;
    for (int unsigned k = 0; k < 6; k++)
      send_request(bal_pkg::CmdInsRear, pick_value(), 0, 0);
    while (stall_hold > 0) @(posedge clk_i);
  endtask

  initial begin
    rst_ni            = 1'b0;
    cmd_if.valid      = 1'b0;
    cmd_if.command    = '0;
    cmd_if.item_value = '0;
    cmd_if.position   = '0;
    shadow_fill       = 0;
    n_errors          = 0;
    n_requests        = 0;
    n_results         = 0;
    stall_hold        = 0;
    rsp_ready_en      = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    rsp_ready_en = 1'b1;
    test_fill_and_overflow();
    test_backpressure();
    test_random_mix(300);
    rsp_ready_en = 1'b0;
    test_random_mix(120);    // stretch with no receiver stalls
    rsp_ready_en = 1'b1;
    test_random_mix(280);

    while (expected_rsps.size() > 0) @(posedge clk_i);
    repeat (Depth + 10) @(posedge clk_i);
    $display("Covered %0d requests and %0d results: all commands, full/empty edges,",
             n_requests, n_results);
    $display("bad positions, duplicates, extreme values and a long receiver stall.");
    if (n_errors == 0 && expected_rsps.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
